// ===== rtl/core/pfrag_pkg.sv =====
// Shared types, widths and constants of the payload fragmenter.
package pfrag_pkg;

   // Payload bytes carried by one fragment.
   localparam int FRAG_BYTES = 64;

   localparam int BYTE_W       = 8;
   localparam int LENGTH_W     = 24;
   localparam int CAPACITY_W   = 26;
   localparam int INDEX_W      = 16;
   localparam int TOTAL_W      = 26;
   localparam int CSR_DATA_W   = 26;
   localparam int CSR_INDEX_W  = 1;
   localparam int HDR_BYTES    = 4;
   localparam int RSP_CNT_W    = 3;
   localparam int POS_W        = $clog2(FRAG_BYTES + 1);

   // Fragment count of a message: ceil(length / FRAG_BYTES), by reciprocal multiplication.
   localparam int DIVIDEND_W   = LENGTH_W + 1;
   localparam int FRAG_N_W     = LENGTH_W + 1;
   localparam int FRAG_LOG2    = $clog2(FRAG_BYTES);
   localparam int FRAG_SHIFT   = DIVIDEND_W + FRAG_LOG2;
   localparam int RECIP_W      = DIVIDEND_W + 2;
   localparam int PROD_W       = DIVIDEND_W + RECIP_W;
   localparam logic [RECIP_W-1:0] FRAG_RECIP =
      RECIP_W'(((64'd1 << FRAG_SHIFT) + 64'(FRAG_BYTES) - 64'd1) / 64'(FRAG_BYTES));

   // Width of length plus four header bytes per fragment.
   localparam int NEED_W       = FRAG_N_W + 3;

   // Number of result beats that one payload byte produces.
   localparam logic [RSP_CNT_W-1:0] RSP_NONE        = RSP_CNT_W'(0);
   localparam logic [RSP_CNT_W-1:0] RSP_ONE         = RSP_CNT_W'(1);
   localparam logic [RSP_CNT_W-1:0] RSP_WITH_HEADER = RSP_CNT_W'(HDR_BYTES + 1);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_ARG  = 2'd1,
      STATUS_BAD_SIZE = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MESSAGE_LENGTH  = 1'b0,
      CSR_OUTPUT_CAPACITY = 1'b1
   } csr_index_type;

   // Configuration as seen by the fragmenting engine.
   typedef struct packed {
      logic [LENGTH_W-1:0]   message_length;
      logic [CAPACITY_W-1:0] output_capacity;
      logic [FRAG_N_W-1:0]   frag_n;
   } pfrag_cfg_type;

   // Everything one accepted payload byte produces: header beats and the closing beat.
   typedef struct packed {
      logic [RSP_CNT_W-1:0]                n_results;
      logic [HDR_BYTES-1:0][BYTE_W-1:0]    header;
      logic [BYTE_W-1:0]                   out_byte;
      status_type                          status;
      logic                                last;
      logic [INDEX_W-1:0]                  fragment_count;
      logic [TOTAL_W-1:0]                  total_length;
   } pfrag_result_type;

endpackage

// ===== rtl/core/payload_fragmenter_unit.sv =====
// Top level of the payload fragmenter: configuration registers, engine and result buffer.
//
// The block takes a message one payload byte per req beat and re-emits it as fragments
// of up to FRAG_BYTES payload bytes, each preceded by a four-byte big-endian header made of
// the 1-based fragment index and the fragment count. The message length and the output
// capacity are written through the csr port; the user must do so only while the block is
// idle, as the block itself does not enforce it. The fragment count is derived by a
// reciprocal multiplier at the moment the length is written, so an item may follow the
// write in the very next cycle. The length, fragment count and capacity checks run on the
// first byte of each message; a failed check gives one rsp beat with last set and a
// non-zero status, and the remaining bytes of that message are then swallowed without any
// rsp beat. A byte is turned into its rsp beats in the cycle it is accepted and held in a
// result buffer of five entries. A byte that opens a fragment yields five rsp beats (four
// header beats and the payload beat), so the req side waits while the header drains; a
// new req beat is accepted in the same cycle as the last buffered rsp beat leaves. Every
// other byte yields one rsp beat, and a dropped byte none. The final rsp beat of a message
// that passes its checks carries the fragment count and the total output length, headers
// included.
module payload_fragmenter_unit (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [7:0]                              req_payload_byte,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [7:0]                              rsp_out_byte,
   output logic [1:0]                              rsp_status,
   output logic                                    rsp_last,
   output logic [15:0]                             rsp_fragment_count,
   output logic [25:0]                             rsp_total_length,

   input  logic                                    csr_write_enable,
   input  logic [pfrag_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pfrag_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import pfrag_pkg::*;

   // Configuration registers and the derived fragment count.
   logic [LENGTH_W-1:0]   length_ff, length_in;
   logic [CAPACITY_W-1:0] capacity_ff, capacity_in;
   logic [FRAG_N_W-1:0]   frag_n_ff, frag_n_in;

   logic [DIVIDEND_W-1:0] dividend;
   logic [PROD_W-1:0]     product;
   logic [FRAG_N_W-1:0]   frag_n_new;

   // Result buffer: four header bytes and one closing entry, drained by a count.
   logic [RSP_CNT_W-1:0]             rsp_cnt_ff, rsp_cnt_in;
   logic [HDR_BYTES-1:0][BYTE_W-1:0] hdr_ff, hdr_in;
   logic [BYTE_W-1:0]                fin_byte_ff, fin_byte_in;
   status_type                       fin_status_ff, fin_status_in;
   logic                             fin_last_ff, fin_last_in;
   logic [INDEX_W-1:0]               fin_count_ff, fin_count_in;
   logic [TOTAL_W-1:0]               fin_total_ff, fin_total_in;

   logic                             req_take;
   logic                             rsp_take;
   logic [1:0]                       hdr_sel;
   pfrag_cfg_type                    cfg;
   pfrag_result_type                 result;

   // Ceiling division of the new length by the fragment size, exact over the full range.
   assign dividend   = DIVIDEND_W'(csr_write_data[LENGTH_W-1:0]) + DIVIDEND_W'(FRAG_BYTES - 1);
   assign product    = PROD_W'(dividend) * PROD_W'(FRAG_RECIP);
   assign frag_n_new = FRAG_N_W'(product >> FRAG_SHIFT);

   always_comb begin
      length_in   = length_ff;
      capacity_in = capacity_ff;
      frag_n_in   = frag_n_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MESSAGE_LENGTH: begin
               length_in = csr_write_data[LENGTH_W-1:0];
               frag_n_in = frag_n_new;
            end
            CSR_OUTPUT_CAPACITY: begin
               capacity_in = csr_write_data[CAPACITY_W-1:0];
            end
            default: begin
               length_in = length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         capacity_ff <= '0;
         frag_n_ff   <= '0;
      end else begin
         length_ff   <= length_in;
         capacity_ff <= capacity_in;
         frag_n_ff   <= frag_n_in;
      end
   end

   assign cfg.message_length  = length_ff;
   assign cfg.output_capacity = capacity_ff;
   assign cfg.frag_n          = frag_n_ff;

   // A new byte may enter once the buffer is empty or its final entry leaves this cycle.
   assign req_ready = (rsp_cnt_ff == RSP_NONE) || ((rsp_cnt_ff == RSP_ONE) && rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_cnt_ff != RSP_NONE;
   assign rsp_take  = rsp_valid && rsp_ready;

   pfrag_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_take),
      .payload_byte (req_payload_byte),
      .cfg          (cfg),
      .result       (result)
   );

   always_comb begin
      rsp_cnt_in    = rsp_cnt_ff;
      hdr_in        = hdr_ff;
      fin_byte_in   = fin_byte_ff;
      fin_status_in = fin_status_ff;
      fin_last_in   = fin_last_ff;
      fin_count_in  = fin_count_ff;
      fin_total_in  = fin_total_ff;
      if (req_take) begin
         rsp_cnt_in    = result.n_results;
         hdr_in        = result.header;
         fin_byte_in   = result.out_byte;
         fin_status_in = result.status;
         fin_last_in   = result.last;
         fin_count_in  = result.fragment_count;
         fin_total_in  = result.total_length;
      end else if (rsp_take) begin
         rsp_cnt_in = rsp_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_cnt_ff <= RSP_NONE;
      end else begin
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff        <= hdr_in;
      fin_byte_ff   <= fin_byte_in;
      fin_status_ff <= fin_status_in;
      fin_last_ff   <= fin_last_in;
      fin_count_ff  <= fin_count_in;
      fin_total_ff  <= fin_total_in;
   end

   // While more than one entry remains, the header bytes go out first, index byte high first.
   assign hdr_sel = 2'(RSP_WITH_HEADER - rsp_cnt_ff);

   always_comb begin
      if (rsp_cnt_ff > RSP_ONE) begin
         rsp_out_byte       = hdr_ff[hdr_sel];
         rsp_status         = STATUS_OK;
         rsp_last           = 1'b0;
         rsp_fragment_count = '0;
         rsp_total_length   = '0;
      end else begin
         rsp_out_byte       = fin_byte_ff;
         rsp_status         = fin_status_ff;
         rsp_last           = fin_last_ff;
         rsp_fragment_count = fin_count_ff;
         rsp_total_length   = fin_total_ff;
      end
   end

endmodule

// ===== rtl/core/pfrag_engine.sv =====
// Message tracking state and per-byte result computation of the payload fragmenter.
module pfrag_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [7:0]                   payload_byte,
   input  pfrag_pkg::pfrag_cfg_type     cfg,
   output pfrag_pkg::pfrag_result_type  result
);
   import pfrag_pkg::*;

   logic [LENGTH_W-1:0] bytes_taken_ff, bytes_taken_in;
   logic [INDEX_W-1:0]  fragment_index_ff, fragment_index_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [INDEX_W-1:0]  fragment_total_ff, fragment_total_in;
   logic [TOTAL_W-1:0]  output_count_ff, output_count_in;
   logic                dropping_ff, dropping_in;

   logic [LENGTH_W-1:0] taken;
   logic                ends;
   logic                first;
   logic [NEED_W-1:0]   need;
   status_type          check;
   logic [INDEX_W-1:0]  total_sel;
   logic [INDEX_W-1:0]  idx;
   logic [TOTAL_W-1:0]  oc_new;
   logic [POS_W-1:0]    pos_inc;

   assign taken     = bytes_taken_ff + 1'b1;
   assign ends      = taken >= cfg.message_length;
   assign first     = bytes_taken_ff == '0;
   assign need      = NEED_W'(cfg.message_length) + (NEED_W'(cfg.frag_n) << 2);
   assign total_sel = first ? cfg.frag_n[INDEX_W-1:0] : fragment_total_ff;
   assign idx       = fragment_index_ff + 1'b1;
   assign pos_inc   = position_ff + 1'b1;
   assign oc_new    = output_count_ff + ((position_ff == '0) ? TOTAL_W'(HDR_BYTES + 1)
                                                             : TOTAL_W'(1));

   // Checks made on the first byte of a message.
   always_comb begin
      if (cfg.message_length == '0) begin
         check = STATUS_BAD_ARG;
      end else if (cfg.frag_n[FRAG_N_W-1:INDEX_W] != '0) begin
         check = STATUS_BAD_SIZE;
      end else if (NEED_W'(cfg.output_capacity) < need) begin
         check = STATUS_BAD_SIZE;
      end else begin
         check = STATUS_OK;
      end
   end

   always_comb begin
      bytes_taken_in    = bytes_taken_ff;
      fragment_index_in = fragment_index_ff;
      position_in       = position_ff;
      fragment_total_in = fragment_total_ff;
      output_count_in   = output_count_ff;
      dropping_in       = dropping_ff;

      result                = '0;
      result.n_results      = RSP_NONE;
      result.status         = STATUS_OK;
      result.header[0]      = idx[15:8];
      result.header[1]      = idx[7:0];
      result.header[2]      = total_sel[15:8];
      result.header[3]      = total_sel[7:0];

      if (accept) begin
         if (dropping_ff) begin
            bytes_taken_in = taken;
            if (ends) begin
               bytes_taken_in = '0;
               dropping_in    = 1'b0;
            end
         end else if (first && (check != STATUS_OK)) begin
            result.n_results = RSP_ONE;
            result.status    = check;
            result.last      = 1'b1;
            if (!ends) begin
               bytes_taken_in = taken;
               dropping_in    = 1'b1;
            end
         end else begin
            result.n_results = (position_ff == '0) ? RSP_WITH_HEADER : RSP_ONE;
            result.out_byte  = payload_byte;
            if (ends) begin
               result.last           = 1'b1;
               result.fragment_count = total_sel;
               result.total_length   = oc_new;
               bytes_taken_in        = '0;
               fragment_index_in     = '0;
               position_in           = '0;
               fragment_total_in     = '0;
               output_count_in       = '0;
            end else begin
               fragment_total_in = total_sel;
               bytes_taken_in    = taken;
               output_count_in   = oc_new;
               if (pos_inc >= POS_W'(FRAG_BYTES)) begin
                  position_in       = '0;
                  fragment_index_in = idx;
               end else begin
                  position_in = pos_inc;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_taken_ff    <= '0;
         fragment_index_ff <= '0;
         position_ff       <= '0;
         fragment_total_ff <= '0;
         output_count_ff   <= '0;
         dropping_ff       <= 1'b0;
      end else begin
         bytes_taken_ff    <= bytes_taken_in;
         fragment_index_ff <= fragment_index_in;
         position_ff       <= position_in;
         fragment_total_ff <= fragment_total_in;
         output_count_ff   <= output_count_in;
         dropping_ff       <= dropping_in;
      end
   end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the payload fragmenter: directed table, random phases, scoreboard.
module tb_top;
   import pfrag_pkg::*;

   // Cycles allowed for the block to settle after the last awaited beat, for instance while it
   // swallows the bytes of a failed message, which give no rsp beat at all.
   localparam int DRAIN_CYCLES    = 12;
   // The receiver holds off once for this long so that the result buffer fills and req stalls.
   localparam int HOLD_OFF_CYCLES = 160;
   // Cycles without any accepted beat or register write before the run is abandoned.
   localparam int STALL_LIMIT     = 3000;
   localparam int RANDOM_BYTES    = 450;
   localparam int PRINT_LIMIT     = 60;
   localparam logic [LENGTH_W-1:0]   LENGTH_MAX   = '1;
   localparam logic [CAPACITY_W-1:0] CAPACITY_MAX = '1;

   // One rsp beat as the scoreboard sees it.
   typedef struct packed {
      logic [7:0]  out_byte;
      status_type  status;
      logic        last;
      logic [15:0] fragment_count;
      logic [25:0] total_length;
   } fragment_beat_type;

   typedef enum logic {
      ROW_WRITE,
      ROW_BYTE
   } row_kind_type;

   // A row of the directed table: either a register write or a payload byte. A byte row may
   // carry the single beat that it must produce; otherwise the predictor supplies the beats.
   typedef struct packed {
      row_kind_type      kind;
      csr_index_type     which;
      logic [25:0]       value;
      logic              typed;
      fragment_beat_type beat;
   } stimulus_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_payload_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_out_byte;
   logic [1:0]             rsp_status;
   logic                   rsp_last;
   logic [15:0]            rsp_fragment_count;
   logic [25:0]            rsp_total_length;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   payload_fragmenter_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_payload_byte   (req_payload_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .rsp_fragment_count (rsp_fragment_count),
      .rsp_total_length   (rsp_total_length),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // Mirror of the two registers and of the message state that the block keeps.
   logic [LENGTH_W-1:0]   mirror_length;
   logic [CAPACITY_W-1:0] mirror_capacity;
   logic [23:0]           taken_so_far;
   logic [15:0]           fragments_done;
   logic [7:0]            fill_of_fragment;
   logic [16:0]           latched_fragments;
   logic [25:0]           bytes_emitted;
   logic                  swallowing;

   fragment_beat_type awaited_fragment_beats[$];
   stimulus_row_type  directed_rows[$];

   // Set by the sender alongside each byte it offers; read by the scoreboard on acceptance.
   logic              row_typed;
   fragment_beat_type row_typed_beat;
   logic              sender_steady;
   // High after a rising edge at which a req beat was offered and held back.
   logic              req_stalled;

   int unsigned mismatch_count;
   int unsigned bytes_accepted;
   int unsigned beats_checked;
   int unsigned messages_closed;
   int unsigned argument_errors;
   int unsigned size_errors;
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic fragment_beat_type make_beat(input logic [7:0] value,
                                                   input status_type code,
                                                   input logic closing,
                                                   input logic [15:0] count,
                                                   input logic [25:0] total);
      fragment_beat_type beat;
      beat.out_byte       = value;
      beat.status         = code;
      beat.last           = closing;
      beat.fragment_count = count;
      beat.total_length   = total;
      return beat;
   endfunction

   function automatic void clear_message_state();
      taken_so_far      = '0;
      fragments_done    = '0;
      fill_of_fragment  = '0;
      latched_fragments = '0;
      bytes_emitted     = '0;
      swallowing        = 1'b0;
   endfunction

   // Output size of a whole message: its payload plus one four-byte header per fragment.
   function automatic int unsigned bytes_needed(input int unsigned length);
      return length + HDR_BYTES * ((length + FRAG_BYTES - 1) / FRAG_BYTES);
   endfunction

   // Works out the rsp beats of one accepted payload byte and queues them in order.
   function automatic void fragment_payload_byte(input logic [7:0] value);
      logic [23:0]  taken_next;
      logic         closes;
      status_type   verdict;
      int unsigned  fragments;
      logic [15:0]  index_next;

      taken_next = taken_so_far + 24'd1;
      closes     = taken_next >= mirror_length;

      // Bytes of a failed message are swallowed, but the message boundary is still tracked.
      if (swallowing) begin
         if (closes) clear_message_state();
         else taken_so_far = taken_next;
         return;
      end

      // The checks only run on the first byte of a message.
      if (taken_so_far == '0) begin
         verdict = STATUS_OK;
         if (mirror_length == '0) begin
            verdict = STATUS_BAD_ARG;
         end else begin
            fragments = (int'(mirror_length) + FRAG_BYTES - 1) / FRAG_BYTES;
            if (fragments > 32'hFFFF || mirror_capacity < bytes_needed(mirror_length))
               verdict = STATUS_BAD_SIZE;
            else
               latched_fragments = 17'(fragments);
         end
         if (verdict != STATUS_OK) begin
            awaited_fragment_beats.push_back(make_beat(8'h00, verdict, 1'b1, '0, '0));
            if (closes) begin
               clear_message_state();
            end else begin
               taken_so_far = taken_next;
               swallowing   = 1'b1;
            end
            return;
         end
      end

      // A byte that opens a fragment is preceded by the big-endian index and count.
      if (fill_of_fragment == '0) begin
         index_next = fragments_done + 16'd1;
         awaited_fragment_beats.push_back(make_beat(index_next[15:8], STATUS_OK, 1'b0, '0, '0));
         awaited_fragment_beats.push_back(make_beat(index_next[7:0], STATUS_OK, 1'b0, '0, '0));
         awaited_fragment_beats.push_back(make_beat(latched_fragments[15:8], STATUS_OK, 1'b0,
                                                    '0, '0));
         awaited_fragment_beats.push_back(make_beat(latched_fragments[7:0], STATUS_OK, 1'b0,
                                                    '0, '0));
         bytes_emitted = bytes_emitted + 26'(HDR_BYTES);
      end

      bytes_emitted = bytes_emitted + 26'd1;
      if (closes) begin
         awaited_fragment_beats.push_back(make_beat(value, STATUS_OK, 1'b1,
                                                    latched_fragments[15:0], bytes_emitted));
         clear_message_state();
         return;
      end

      awaited_fragment_beats.push_back(make_beat(value, STATUS_OK, 1'b0, '0, '0));
      taken_so_far     = taken_next;
      fill_of_fragment = fill_of_fragment + 8'd1;
      if (fill_of_fragment >= FRAG_BYTES) begin
         fill_of_fragment = '0;
         fragments_done   = fragments_done + 16'd1;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] wanted);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch on rsp beat %0d: %s is %0h, should be %0h",
                  beats_checked, what, got, wanted);
      mismatch_count++;
   endtask

   // Scoreboard. Register writes, accepted req beats and accepted rsp beats are all taken in
   // this one process at the rising edge, so the prediction of a byte is always queued before
   // any of its beats can be compared, whatever order the simulator runs processes in.
   always @(posedge clock) begin : scoreboard
      fragment_beat_type wanted;
      int unsigned       depth_before;

      if (reset) begin
         mirror_length   = '0;
         mirror_capacity = '0;
         req_stalled     = 1'b0;
         clear_message_state();
         awaited_fragment_beats.delete();
      end else begin
         req_stalled = req_valid && !req_ready;

         if (csr_write_enable) begin
            if (csr_index == CSR_MESSAGE_LENGTH)
               mirror_length = csr_write_data[LENGTH_W-1:0];
            else
               mirror_capacity = csr_write_data[CAPACITY_W-1:0];
         end

         if (req_valid && req_ready) begin
            depth_before = awaited_fragment_beats.size();
            fragment_payload_byte(req_payload_byte);
            // A directed row with its beat written out replaces what was predicted for it.
            if (row_typed) begin
               while (awaited_fragment_beats.size() > depth_before)
                  void'(awaited_fragment_beats.pop_back());
               awaited_fragment_beats.push_back(row_typed_beat);
            end
            bytes_accepted++;
         end

         if (rsp_valid && rsp_ready) begin
            if (awaited_fragment_beats.size() == 0) begin
               report_mismatch("beat with nothing awaited, out_byte", rsp_out_byte, '0);
            end else begin
               wanted = awaited_fragment_beats.pop_front();
               if (rsp_out_byte !== wanted.out_byte)
                  report_mismatch("out_byte", rsp_out_byte, wanted.out_byte);
               if (rsp_status !== wanted.status)
                  report_mismatch("status", rsp_status, wanted.status);
               if (rsp_last !== wanted.last)
                  report_mismatch("last", rsp_last, wanted.last);
               if (rsp_fragment_count !== wanted.fragment_count)
                  report_mismatch("fragment_count", rsp_fragment_count, wanted.fragment_count);
               if (rsp_total_length !== wanted.total_length)
                  report_mismatch("total_length", rsp_total_length, wanted.total_length);
               if (wanted.status == STATUS_BAD_ARG) argument_errors++;
               if (wanted.status == STATUS_BAD_SIZE) size_errors++;
               if (wanted.status == STATUS_OK && wanted.last) messages_closed++;
            end
            beats_checked++;
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timed out after %0d cycles without progress", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver. It stalls at random with a chance of about 19 percent, runs without a stall for a
   // stretch of beats, and once, while a req beat is being held back, holds off long enough for the
   // result buffer to stay full and keep req stalled.
   initial begin : receiver
      int unsigned hold_count;
      logic        held;

      rsp_ready = 1'b0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && beats_checked >= 200 && req_stalled) begin
            held      = 1'b1;
            rsp_ready = 1'b0;
            for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++)
               @(negedge clock);
         end
         if (beats_checked >= 350 && beats_checked < 500)
            rsp_ready = 1'b1;
         else
            rsp_ready = ($urandom_range(99) >= 19);
      end
   end

   // Waits until every awaited beat has been received and the block has had time to finish
   // any swallowed bytes. Leaves req idle. The watchdog bounds the wait.
   task automatic settle_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_fragment_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type which, input logic [25:0] value);
      settle_block();
      csr_write_enable = 1'b1;
      csr_index        = which;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Offers one payload byte and returns at the rising edge at which it is taken. Valid stays
   // high afterwards so that back-to-back bytes need no gap.
   task automatic offer_byte(input logic [7:0] value, input logic typed,
                             input fragment_beat_type typed_beat);
      @(negedge clock);
      while (!sender_steady && $urandom_range(99) < 19) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_payload_byte = value;
      row_typed        = typed;
      row_typed_beat   = typed_beat;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic void add_write(input csr_index_type which, input logic [25:0] value);
      stimulus_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.which = which;
      row.value = value;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_byte(input logic [7:0] value, input logic typed,
                                    input fragment_beat_type beat);
      stimulus_row_type row;
      row       = '0;
      row.kind  = ROW_BYTE;
      row.value = 26'(value);
      row.typed = typed;
      row.beat  = beat;
      directed_rows.push_back(row);
   endfunction

   initial begin : stimulus
      fragment_beat_type bad_arg;
      fragment_beat_type bad_size;
      fragment_beat_type none;
      int unsigned       random_sent;
      int unsigned       phases;
      int unsigned       pick;
      int unsigned       length;
      int unsigned       capacity;
      int unsigned       burst;
      int unsigned       k;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload_byte = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_MESSAGE_LENGTH;
      csr_write_data   = '0;
      row_typed        = 1'b0;
      row_typed_beat   = '0;
      sender_steady    = 1'b0;
      mismatch_count   = 0;
      bytes_accepted   = 0;
      beats_checked    = 0;
      messages_closed  = 0;
      argument_errors  = 0;
      size_errors      = 0;
      random_sent      = 0;
      phases           = 0;

      bad_arg  = make_beat(8'h00, STATUS_BAD_ARG, 1'b1, '0, '0);
      bad_size = make_beat(8'h00, STATUS_BAD_SIZE, 1'b1, '0, '0);
      none     = '0;

      // Straight after reset the length is zero, so each byte is an argument error of its own.
      add_byte(8'h00, 1'b1, bad_arg);
      add_byte(8'hFF, 1'b1, bad_arg);
      // A one-byte message that exactly fills the capacity, then the same with one byte short:
      // the error closes the message at once and the next byte opens a new one.
      add_write(CSR_OUTPUT_CAPACITY, 26'd5);
      add_write(CSR_MESSAGE_LENGTH, 26'd1);
      add_byte(8'hA5, 1'b0, none);
      add_write(CSR_OUTPUT_CAPACITY, 26'd4);
      add_byte(8'h3C, 1'b1, bad_size);
      add_byte(8'hC3, 1'b1, bad_size);
      // Zero capacity: the first byte fails and the other two are swallowed.
      add_write(CSR_MESSAGE_LENGTH, 26'd3);
      add_write(CSR_OUTPUT_CAPACITY, 26'd0);
      add_byte(8'h01, 1'b1, bad_size);
      add_byte(8'h80, 1'b0, none);
      add_byte(8'h7F, 1'b0, none);
      // The capacity drops to zero mid-message; it only bites on the next message.
      add_write(CSR_OUTPUT_CAPACITY, 26'd7);
      add_byte(8'h11, 1'b0, none);
      add_write(CSR_OUTPUT_CAPACITY, 26'd0);
      add_byte(8'h22, 1'b0, none);
      add_byte(8'h33, 1'b0, none);
      add_byte(8'h44, 1'b1, bad_size);
      // Shortening the length while swallowing ends the failed message early.
      add_write(CSR_MESSAGE_LENGTH, 26'd2);
      add_byte(8'h55, 1'b0, none);
      // Largest length and capacity: far too many fragments.
      add_write(CSR_MESSAGE_LENGTH, 26'(LENGTH_MAX));
      add_write(CSR_OUTPUT_CAPACITY, 26'(CAPACITY_MAX));
      add_byte(8'h66, 1'b1, bad_size);
      add_write(CSR_MESSAGE_LENGTH, 26'd1);
      add_byte(8'h77, 1'b0, none);
      // Exactly 65535 fragments is allowed; the length is then cut short after one byte, so
      // the closing beat still reports the count latched at the start.
      add_write(CSR_MESSAGE_LENGTH, 26'(FRAG_BYTES * 65535));
      add_byte(8'hFF, 1'b0, none);
      add_write(CSR_MESSAGE_LENGTH, 26'd2);
      add_byte(8'h00, 1'b1, make_beat(8'h00, STATUS_OK, 1'b1, 16'hFFFF, 26'd6));
      // One fragment more than the header can count.
      add_write(CSR_MESSAGE_LENGTH, 26'(FRAG_BYTES * 65535 + 1));
      add_byte(8'h5A, 1'b1, bad_size);
      add_write(CSR_MESSAGE_LENGTH, 26'd1);
      add_byte(8'hA5, 1'b0, none);
      // A length lowered below the bytes already taken closes the message on the next byte.
      add_write(CSR_MESSAGE_LENGTH, 26'd5);
      add_write(CSR_OUTPUT_CAPACITY, 26'd25);
      add_byte(8'h0F, 1'b0, none);
      add_byte(8'hF0, 1'b0, none);
      add_write(CSR_MESSAGE_LENGTH, 26'd1);
      add_byte(8'h99, 1'b0, none);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE)
            write_register(directed_rows[i].which, directed_rows[i].value);
         else
            offer_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                       directed_rows[i].beat);
      end

      // Random phases. Most use a short length with enough capacity, so that whole messages
      // and fragment boundaries go through; the rest give size and argument errors, or use
      // wide random register values, and are cut short by the next phase's writes.
      while (random_sent < RANDOM_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            length   = ($urandom_range(9) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 70);
            capacity = bytes_needed(length) + (($urandom_range(1) == 0) ? 0 : $urandom_range(40));
         end else if (pick < 80) begin
            length   = $urandom_range(1, 130);
            capacity = bytes_needed(length) - 1;
         end else if (pick < 85) begin
            length   = 0;
            capacity = $urandom & 32'(CAPACITY_MAX);
         end else if (pick < 95) begin
            length   = $urandom & 32'(LENGTH_MAX);
            capacity = $urandom & 32'(CAPACITY_MAX);
         end else begin
            length   = $urandom_range(1, 70);
            capacity = $urandom & 32'(CAPACITY_MAX);
         end
         write_register(CSR_MESSAGE_LENGTH, 26'(length));
         write_register(CSR_OUTPUT_CAPACITY, 26'(capacity));

         if (length == 0 || length > 200) begin
            burst = $urandom_range(1, 12);
         end else begin
            burst = length * $urandom_range(1, 3);
            if ($urandom_range(3) == 0) burst = burst - $urandom_range(0, length - 1);
         end
         if (burst > 260) burst = 260;

         for (k = 0; k < burst && random_sent < RANDOM_BYTES; k++) begin
            sender_steady = (random_sent >= 150 && random_sent < 260);
            offer_byte(8'($urandom_range(255)), 1'b0, none);
            random_sent++;
         end
         phases++;
      end

      settle_block();

      $display("Sent %0d payload bytes under %0d register settings; compared %0d rsp beats.",
               bytes_accepted, phases + 1, beats_checked);
      $display("Closed %0d messages, saw %0d argument and %0d size errors, %0d mismatches.",
               messages_closed, argument_errors, size_errors, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
